// File: hdl/avp_deframer_assert.svh
// Assertion macros for the AVP deframer.
`ifndef AVP_DEFRAMER_ASSERT_SVH
`define AVP_DEFRAMER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define AVP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define AVP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define AVP_ASSERT(lbl, clk, rst_n, prop, msg)
`define AVP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: hdl/avp_pkg.sv
package avp_pkg;

  localparam logic [31:0] DEFAULT_CODE = 32'd79;
  localparam logic [23:0] HDR_BYTES    = 24'd8;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_PAYLOAD,
    PH_PAD,
    PH_DRAIN
  } phase_e;

  typedef enum logic [1:0] {
    KIND_DATA,
    KIND_OK,
    KIND_FAIL
  } kind_e;

  typedef enum logic [2:0] {
    CAUSE_NONE,
    CAUSE_SHORT_HDR,
    CAUSE_BAD_CODE,
    CAUSE_BAD_LEN,
    CAUSE_SHORT_PAY
  } cause_e;

  typedef struct packed {
    logic [7:0] data;
    kind_e      kind;
    cause_e     cause;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

  function automatic result_t mk_data(input logic [7:0] b);
    result_t r;
    r.data  = b;
    r.kind  = KIND_DATA;
    r.cause = CAUSE_NONE;
    r.last  = 1'b0;
    return r;
  endfunction

  function automatic result_t mk_ok();
    result_t r;
    r.data  = 8'd0;
    r.kind  = KIND_OK;
    r.cause = CAUSE_NONE;
    r.last  = 1'b1;
    return r;
  endfunction

  function automatic result_t mk_fail(input cause_e c);
    result_t r;
    r.data  = 8'd0;
    r.kind  = KIND_FAIL;
    r.cause = c;
    r.last  = 1'b1;
    return r;
  endfunction

endpackage

// File: hdl/avp_deframer.sv
// AVP deframer: one stream byte per cycle in, payload bytes and per-AVP status out.
// An accepted byte is registered first; its results then go into the result queue.
// Throughput: one input word per cycle; a 4-entry result queue absorbs the
// two-result words that close an AVP, and the input stalls when it has under two free slots.
// Reset: parser returns to header phase, queue empties, expected code becomes 79.
`include "avp_deframer_assert.svh"

module avp_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  input  logic        stream_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  data_byte_o,
  output logic [1:0]  kind_o,
  output logic [2:0]  fail_cause_o,
  output logic        last_o
);

  logic [31:0]      exp_code_q;
  logic             room;
  avp_pkg::push_t   push;
  avp_pkg::result_t head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_code_q <= avp_pkg::DEFAULT_CODE;
    end else if (cfg_we_i) begin
      exp_code_q <= cfg_wdata_i;
    end
  end

  avp_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .exp_code_i   (exp_code_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_byte_i    (in_byte_i),
    .stream_end_i (stream_end_i),
    .room_i       (room),
    .push_o       (push)
  );

  avp_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .head_o      (head)
  );

  assign data_byte_o  = head.data;
  assign kind_o       = head.kind;
  assign fail_cause_o = head.cause;
  assign last_o       = head.last;

  `AVP_ASSERT_IMPL(a_push_room, clk_i, rst_ni, push.n != 2'd0, room, "push without queue room")
  `AVP_ASSERT(a_push_max, clk_i, rst_ni, push.n != 2'd3, "more than two results per word")
  `AVP_ASSERT_IMPL(a_pair_order, clk_i, rst_ni, push.n == 2'd2, (push.r0.kind == avp_pkg::KIND_DATA) && push.r1.last, "two-result word not data then status")

endmodule

// File: hdl/avp_parser.sv
module avp_parser (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [31:0]    exp_code_i,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [7:0]     in_byte_i,
  input  logic           stream_end_i,
  input  logic           room_i,
  output avp_pkg::push_t push_o
);

  logic                iv_q;
  logic [7:0]          ib_q;
  logic                ie_q;
  logic                go;

  avp_pkg::phase_e     ph_q, ph_d;
  logic [23:0]         cnt_q, cnt_d;
  logic [31:0]         code_q, code_d;
  logic [23:0]         len_q, len_d;
  logic [1:0]          pad_q, pad_d;

  logic [31:0]         code_n;
  logic [23:0]         len_n;
  logic [23:0]         cnt_dec;
  logic [1:0]          pad_dec;
  logic                restart;
  avp_pkg::push_t      push;

  assign go         = iv_q & room_i;
  assign in_stall_o = iv_q & ~room_i;

  // input word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_q <= 1'b0;
    end else if (!in_stall_o) begin
      iv_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      ib_q <= in_byte_i;
      ie_q <= stream_end_i;
    end
  end

  assign code_n  = (cnt_q < 24'd4) ? {code_q[23:0], ib_q} : code_q;
  assign len_n   = (cnt_q >= 24'd5) ? {len_q[15:0], ib_q} : len_q;
  assign cnt_dec = cnt_q - 24'd1;
  assign pad_dec = pad_q - 2'd1;

  always_comb begin
    ph_d    = ph_q;
    cnt_d   = cnt_q;
    code_d  = code_q;
    len_d   = len_q;
    pad_d   = pad_q;
    restart = 1'b0;
    push.n  = 2'd0;
    push.r0 = avp_pkg::mk_data(8'd0);
    push.r1 = avp_pkg::mk_data(8'd0);

    case (ph_q)
      avp_pkg::PH_PAYLOAD: begin
        push.n  = 2'd1;
        push.r0 = avp_pkg::mk_data(ib_q);
        cnt_d   = cnt_dec;
        if (cnt_dec == 24'd0 && pad_q == 2'd0) begin
          push.n  = 2'd2;
          push.r1 = avp_pkg::mk_ok();
          restart = 1'b1;
        end else begin
          if (cnt_dec == 24'd0) begin
            ph_d = avp_pkg::PH_PAD;
          end
          if (ie_q) begin
            push.n  = 2'd2;
            push.r1 = avp_pkg::mk_fail(avp_pkg::CAUSE_SHORT_PAY);
            restart = 1'b1;
          end
        end
      end
      avp_pkg::PH_PAD: begin
        pad_d = pad_dec;
        if (pad_dec == 2'd0) begin
          push.n  = 2'd1;
          push.r0 = avp_pkg::mk_ok();
          restart = 1'b1;
        end else if (ie_q) begin
          push.n  = 2'd1;
          push.r0 = avp_pkg::mk_fail(avp_pkg::CAUSE_SHORT_PAY);
          restart = 1'b1;
        end
      end
      avp_pkg::PH_DRAIN: begin
        restart = ie_q;
      end
      avp_pkg::PH_HEADER: begin
        code_d = code_n;
        len_d  = len_n;
        cnt_d  = cnt_q + 24'd1;
        if (cnt_q < 24'd7) begin
          if (ie_q) begin
            push.n  = 2'd1;
            push.r0 = avp_pkg::mk_fail(avp_pkg::CAUSE_SHORT_HDR);
            restart = 1'b1;
          end
        end else if (code_n != exp_code_i) begin
          push.n  = 2'd1;
          push.r0 = avp_pkg::mk_fail(avp_pkg::CAUSE_BAD_CODE);
          restart = ie_q;
          ph_d    = avp_pkg::PH_DRAIN;
        end else if (len_n < avp_pkg::HDR_BYTES) begin
          push.n  = 2'd1;
          push.r0 = avp_pkg::mk_fail(avp_pkg::CAUSE_BAD_LEN);
          restart = ie_q;
          ph_d    = avp_pkg::PH_DRAIN;
        end else begin
          pad_d = 2'd0 - len_n[1:0];
          cnt_d = len_n - avp_pkg::HDR_BYTES;
          if (len_n != avp_pkg::HDR_BYTES) begin
            ph_d = avp_pkg::PH_PAYLOAD;
          end else if (len_n[1:0] != 2'd0) begin
            ph_d = avp_pkg::PH_PAD;
          end
          if (len_n == avp_pkg::HDR_BYTES && len_n[1:0] == 2'd0) begin
            push.n  = 2'd1;
            push.r0 = avp_pkg::mk_ok();
            restart = 1'b1;
          end else if (ie_q) begin
            push.n  = 2'd1;
            push.r0 = avp_pkg::mk_fail(avp_pkg::CAUSE_SHORT_PAY);
            restart = 1'b1;
          end
        end
      end
      default: begin
        restart = 1'b1;
      end
    endcase

    if (restart) begin
      ph_d   = avp_pkg::PH_HEADER;
      cnt_d  = 24'd0;
      code_d = 32'd0;
      len_d  = 24'd0;
      pad_d  = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= avp_pkg::PH_HEADER;
      cnt_q  <= 24'd0;
      code_q <= 32'd0;
      len_q  <= 24'd0;
      pad_q  <= 2'd0;
    end else if (go) begin
      ph_q   <= ph_d;
      cnt_q  <= cnt_d;
      code_q <= code_d;
      len_q  <= len_d;
      pad_q  <= pad_d;
    end
  end

  always_comb begin
    push_o = push;
    if (!go) begin
      push_o.n = 2'd0;
    end
  end

endmodule

// File: hdl/avp_outq.sv
module avp_outq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  avp_pkg::push_t   push_i,
  output logic             room_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output avp_pkg::result_t head_o
);

  avp_pkg::result_t mem_q [4];
  logic [1:0]       wp_q;
  logic [1:0]       rp_q;
  logic [2:0]       cnt_q;
  logic             pop;

  assign out_valid_o = cnt_q != 3'd0;
  assign pop         = out_valid_o & ~out_stall_i;
  assign room_o      = cnt_q <= 3'd2;
  assign head_o      = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      mem_q[wp_q] <= push_i.r0;
    end
    if (push_i.n == 2'd2) begin
      mem_q[wp_q + 2'd1] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 2'd0;
      rp_q  <= 2'd0;
      cnt_q <= 3'd0;
    end else begin
      wp_q  <= wp_q + push_i.n;
      rp_q  <= rp_q + {1'b0, pop};
      cnt_q <= cnt_q + {1'b0, push_i.n} - {2'b00, pop};
    end
  end

endmodule

// File: tb/sv/avp_deframer_tb.sv
`timescale 1ns / 100ps

module avp_deframer_tb;
  import avp_pkg::*;

  typedef struct packed {
    logic [7:0] value;
    logic       stop;
  } stream_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  in_byte_i = '0;
  logic        stream_end_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  data_byte_o;
  logic [1:0]  kind_o;
  logic [2:0]  fail_cause_o;
  logic        last_o;

  avp_deframer dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_byte_i    (in_byte_i),
    .stream_end_i (stream_end_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .data_byte_o  (data_byte_o),
    .kind_o       (kind_o),
    .fail_cause_o (fail_cause_o),
    .last_o       (last_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // deframer state as seen by the checker
  phase_e      frame_phase = PH_HEADER;
  logic [23:0] hdr_seen = '0;
  logic [23:0] pay_left = '0;
  logic [31:0] code_acc = '0;
  logic [23:0] len_acc = '0;
  logic [1:0]  pad_left = '0;
  logic [31:0] want_code = DEFAULT_CODE;

  stream_word_t pending_words[$];
  result_t      due_results[$];

  int words_queued = 0;
  int words_taken = 0;
  int errors = 0;
  int n_payload = 0;
  int n_ok = 0;
  int n_fail = 0;
  int n_codes = 1;

  bit in_taken = 1'b0;
  bit out_taken = 1'b0;
  bit in_steady = 1'b0;
  bit out_steady = 1'b0;
  int in_wait = 0;
  int out_wait = 0;

  function automatic result_t make_result(kind_e k, cause_e c, logic [7:0] d);
    result_t r;
    r.data  = d;
    r.kind  = k;
    r.cause = c;
    r.last  = (k != KIND_DATA);
    return r;
  endfunction

  task automatic clear_frame();
    frame_phase = PH_HEADER;
    hdr_seen = '0;
    pay_left = '0;
    code_acc = '0;
    len_acc = '0;
    pad_left = '0;
  endtask

  task automatic close_avp(kind_e k, cause_e c, logic restart);
    due_results.push_back(make_result(k, c, 8'd0));
    if (restart) clear_frame();
    else frame_phase = PH_DRAIN;
  endtask

  task automatic deframe_byte(input logic [7:0] b, input logic e);
    case (frame_phase)
      PH_PAYLOAD: begin
        due_results.push_back(make_result(KIND_DATA, CAUSE_NONE, b));
        pay_left = pay_left - 24'd1;
        if (pay_left == 0) begin
          if (pad_left == 0) begin
            close_avp(KIND_OK, CAUSE_NONE, 1'b1);
            return;
          end
          frame_phase = PH_PAD;
        end
        if (e) close_avp(KIND_FAIL, CAUSE_SHORT_PAY, 1'b1);
      end
      PH_PAD: begin
        pad_left = pad_left - 2'd1;
        if (pad_left == 0) close_avp(KIND_OK, CAUSE_NONE, 1'b1);
        else if (e) close_avp(KIND_FAIL, CAUSE_SHORT_PAY, 1'b1);
      end
      PH_DRAIN: begin
        if (e) clear_frame();
      end
      default: begin
        if (hdr_seen < 4) code_acc = {code_acc[23:0], b};
        else if (hdr_seen >= 5) len_acc = {len_acc[15:0], b};
        hdr_seen = hdr_seen + 24'd1;
        if (hdr_seen < HDR_BYTES) begin
          if (e) close_avp(KIND_FAIL, CAUSE_SHORT_HDR, 1'b1);
        end else if (code_acc != want_code) begin
          close_avp(KIND_FAIL, CAUSE_BAD_CODE, e);
        end else if (len_acc < HDR_BYTES) begin
          close_avp(KIND_FAIL, CAUSE_BAD_LEN, e);
        end else begin
          pad_left = 2'd0 - len_acc[1:0];
          pay_left = len_acc - HDR_BYTES;
          if (pay_left != 0) frame_phase = PH_PAYLOAD;
          else if (pad_left != 0) frame_phase = PH_PAD;
          else begin
            close_avp(KIND_OK, CAUSE_NONE, 1'b1);
            return;
          end
          if (e) close_avp(KIND_FAIL, CAUSE_SHORT_PAY, 1'b1);
        end
      end
    endcase
  endtask

  function automatic int draw_wait(bit steady);
    return steady ? 0 : int'($urandom_range(0, 6));
  endfunction

  // checker: results first, then the incoming word
  always @(posedge clk_i) begin
    result_t want;
    in_taken = 1'b0;
    out_taken = 1'b0;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        out_taken = 1'b1;
        if (kind_o == KIND_DATA) n_payload++;
        else if (kind_o == KIND_OK) n_ok++;
        else n_fail++;
        if (due_results.size() == 0) begin
          $error("unexpected result: kind %0d data %0d cause %0d", kind_o, data_byte_o,
                 fail_cause_o);
          errors++;
        end else begin
          want = due_results.pop_front();
          if (data_byte_o !== want.data) begin
            $error("data_byte: expected %0d, got %0d", want.data, data_byte_o);
            errors++;
          end
          if (kind_o !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, kind_o);
            errors++;
          end
          if (fail_cause_o !== want.cause) begin
            $error("fail_cause: expected %0d, got %0d", want.cause, fail_cause_o);
            errors++;
          end
          if (last_o !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, last_o);
            errors++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        in_taken = 1'b1;
        words_taken++;
        deframe_byte(in_byte_i, stream_end_i);
      end
    end
  end

  // byte driver
  always @(negedge clk_i) begin
    stream_word_t w;
    if (rst_ni) begin
      if (in_taken) begin
        void'(pending_words.pop_front());
        if ($urandom_range(0, 39) == 0) in_steady = !in_steady;
        in_wait = draw_wait(in_steady);
      end
      if (in_valid_i && !in_taken) begin
        // hold word while stalled
      end else if (in_wait > 0) begin
        in_wait--;
        in_valid_i <= 1'b0;
      end else if (pending_words.size() > 0) begin
        w = pending_words[0];
        in_byte_i <= w.value;
        stream_end_i <= w.stop;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result sink back-pressure
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_taken) begin
        if ($urandom_range(0, 39) == 0) out_steady = !out_steady;
        out_wait = draw_wait(out_steady);
      end
      if (out_wait > 0) begin
        out_wait--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic push_word(input logic [7:0] b, input logic e);
    stream_word_t w;
    w.value = b;
    w.stop = e;
    pending_words.push_back(w);
    words_queued++;
  endtask

  function automatic logic [7:0] avp_byte(logic [31:0] code, logic [23:0] len, int i);
    if (i < 4) return code[31 - 8 * i -: 8];
    if (i == 4 || i >= 8) return 8'($urandom);
    return len[23 - 8 * (i - 5) -: 8];
  endfunction

  // cut: index of the byte carrying stream_end, or -1 for the whole AVP
  task automatic queue_avp(input logic [31:0] code, input logic [23:0] len, input int cut,
                           input bit end_last, input int tail);
    int total;
    int n;
    total = (len < HDR_BYTES) ? 8 : int'(len) + ((4 - int'(len[1:0])) & 3);
    n = (cut >= 0) ? cut + 1 : total;
    for (int i = 0; i < n; i++)
      push_word(avp_byte(code, len, i), (i == n - 1) && (cut >= 0 || end_last));
    for (int i = 0; i < tail; i++)
      push_word(8'($urandom), i == tail - 1);
  endtask

  task automatic queue_random(input int n_bytes);
    int target;
    int pick;
    int t;
    int total;
    logic [31:0] bad;
    logic [23:0] len;
    target = words_queued + n_bytes;
    while (words_queued < target) begin
      pick = $urandom_range(0, 99);
      bad = want_code ^ (32'd1 << $urandom_range(0, 31));
      if ($urandom_range(0, 1) == 0) bad = $urandom;
      if (bad == want_code) bad = ~want_code;
      t = $urandom_range(0, 5);
      if (pick < 55) begin
        len = ($urandom_range(0, 9) == 0) ? 24'(8 + $urandom_range(0, 60))
                                          : 24'(8 + $urandom_range(0, 16));
        queue_avp(want_code, len, -1, $urandom_range(0, 3) == 0, 0);
      end else if (pick < 65) begin
        queue_avp(bad, 24'(8 + $urandom_range(0, 22)), -1, t == 0, t);
      end else if (pick < 72) begin
        queue_avp(want_code, 24'($urandom_range(0, 7)), -1, t == 0, t);
      end else if (pick < 80) begin
        queue_avp(want_code, 24'(8 + $urandom_range(0, 16)), $urandom_range(0, 6), 0, 0);
      end else if (pick < 92) begin
        len = 24'(9 + $urandom_range(0, 31));
        total = int'(len) + ((4 - int'(len[1:0])) & 3);
        queue_avp(want_code, len, $urandom_range(7, total - 2), 0, 0);
      end else if (pick < 96) begin
        len = 24'($urandom_range(41, 24'hFFFFFF));
        queue_avp(want_code, len, 7 + $urandom_range(0, 6), 0, 0);
      end else begin
        t = $urandom_range(1, 12);
        for (int i = 0; i < t; i++)
          push_word(8'($urandom), (i == t - 1) || ($urandom_range(0, 3) == 0));
      end
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (words_taken != words_queued || due_results.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_code(input logic [31:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    want_code = v;
    n_codes++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    queue_avp(DEFAULT_CODE, 24'd8, -1, 0, 0);
    queue_avp(DEFAULT_CODE, 24'd13, -1, 1, 0);
    queue_avp(DEFAULT_CODE, 24'd12, 11, 0, 0);
    queue_avp(DEFAULT_CODE, 24'd14, 9, 0, 0);
    queue_avp(DEFAULT_CODE, 24'd9, 10, 0, 0);
    queue_avp(DEFAULT_CODE, 24'd20, 7, 0, 0);
    queue_avp(DEFAULT_CODE, 24'd10, 3, 0, 0);
    queue_avp(DEFAULT_CODE ^ 32'h8000_0000, 24'd16, -1, 0, 3);
    queue_avp(~DEFAULT_CODE, 24'd8, -1, 1, 0);
    queue_avp(DEFAULT_CODE, 24'd5, -1, 0, 2);
    queue_avp(DEFAULT_CODE, 24'd0, -1, 1, 0);
    queue_avp(32'd1, 24'd3, -1, 0, 1);
    queue_avp(DEFAULT_CODE, 24'hFFFFFF, 9, 0, 0);
    queue_avp(DEFAULT_CODE, 24'd10, -1, 0, 0);
    queue_random(100);
    wait_idle();

    write_code(32'h0000_0000);
    queue_random(100);
    wait_idle();

    write_code(32'hFFFF_FFFF);
    queue_random(110);
    wait_idle();

    write_code($urandom);
    queue_random(110);
    wait_idle();

    write_code(DEFAULT_CODE);
    queue_random(100);
    wait_idle();

    repeat (8) @(negedge clk_i);
    $display("Sent %0d stream bytes under %0d code settings; checked %0d payload bytes,",
             words_taken, n_codes, n_payload);
    $display("%0d good AVPs and %0d failed AVPs.", n_ok, n_fail);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
